>>> sv/score_sorted_length_budget_bin_defines.svh
// assertion macros for the score-sorted length budget bin
`ifndef SCORE_SORTED_LENGTH_BUDGET_BIN_DEFINES_SVH
`define SCORE_SORTED_LENGTH_BUDGET_BIN_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SSLBB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SSLBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sslbb_pkg.sv
// shared types and constants for the score-sorted length budget bin
`timescale 1ns / 1ps

package sslbb_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;
   localparam int LEN_W               = 16;
   localparam int SCORE_W             = 16;
   localparam int BUDGET_W            = 20;
   localparam int COUNT_OUT_W         = 5;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 20'd300;
   localparam logic [BUDGET_W-1:0] TOTAL_MAX    = 20'hFFFFF;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [LEN_W-1:0]   length;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_SHIFT_LEFT,
      CMD_INSERT
   } cell_cmd_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_cmd_type cmd;
      logic         front;
      entry_type    new_entry;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP,
      ST_INSERT,
      ST_EVICT,
      ST_FINISH
   } state_type;

endpackage

>>> sv/sslbb_cell.sv
// one storage cell of the sorted chain: hold, shift toward head, or insert
`timescale 1ns / 1ps

module sslbb_cell
   import sslbb_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   input  logic          before_in,
   output entry_type     entry,
   output logic          before_out
);

   entry_type entry_ff;
   entry_type entry_in;

   // this cell stays ahead of the insert point
   assign before_out = occupied && !ctrl.front &&
                       (entry_ff.score <= ctrl.new_entry.score);

   always_comb begin
      unique case (ctrl.cmd)
         CMD_SHIFT_LEFT: entry_in = right_entry;
         CMD_INSERT: begin
            if (before_out) begin
               entry_in = entry_ff;
            end else if (before_in) begin
               entry_in = ctrl.new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> sv/score_sorted_length_budget_bin.sv
// top level: score-sorted length budget bin built from a chain of cells
`timescale 1ns / 1ps
// usage
//   req channel (valid/ready) offers one alignment entry: length and score.
//   rsp channel (valid/ready) returns one result per request: accepted flag,
//   evicted count, overflow flag, entry count, total length, lowest score.
//   csr channel (valid/ready, always ready) writes length_budget; write it
//   only while no request is in flight.
// timing
//   one request is worked at a time, taken only in the idle state, the next
//   one in the cycle after the result loads. a plain insert passes the insert
//   state, then finish; at the budget an eviction pass follows the insert (one
//   shift of the whole chain per cycle, one per entry evicted); a full bin
//   drops its head first; a rejected request goes straight to finish.
// reset
//   synchronous, active high: bin empty, total length zero, budget 300.
//   cell contents are not cleared; only cells below the entry count are used.
// stall
//   the result sits in an output register; the next request is accepted
//   while it waits, but a finished request holds in its last state until the
//   output register frees up.
module score_sorted_length_budget_bin
   import sslbb_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
)(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [LEN_W-1:0]       req_entry_length,
   input  logic [SCORE_W-1:0]     req_entry_score,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_accepted,
   output logic [COUNT_OUT_W-1:0] rsp_evicted_count,
   output logic                   rsp_capacity_overflow,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [BUDGET_W-1:0]    rsp_total_length,
   output logic [SCORE_W-1:0]     rsp_lowest_score,
   // budget register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [BUDGET_W-1:0]    csr_length_budget
);

`include "score_sorted_length_budget_bin_defines.svh"

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   // exact running sum of up to MAX_ENTRIES lengths
   localparam int SUM_W = LEN_W + $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (SUM_W > BUDGET_W) ? SUM_W : BUDGET_W;

   // control state
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [BUDGET_W-1:0]  budget_ff, budget_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // request held while it is worked
   entry_type            work_ff, work_in;
   logic                 front_ff, front_in;
   logic                 evict_en_ff, evict_en_in;
   logic                 accepted_ff, accepted_in;
   logic                 overflow_ff, overflow_in;
   logic [CNT_W-1:0]     evicted_ff, evicted_in;

   // result register
   logic                   rsp_accepted_ff, rsp_accepted_in;
   logic [COUNT_OUT_W-1:0] rsp_evicted_ff, rsp_evicted_in;
   logic                   rsp_overflow_ff, rsp_overflow_in;
   logic [COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [BUDGET_W-1:0]    rsp_total_ff, rsp_total_in;
   logic [SCORE_W-1:0]     rsp_lowest_ff, rsp_lowest_in;

   // chain wiring
   cell_ctrl_type        cell_ctrl;
   cell_cmd_type         cell_cmd;
   entry_type            cell_entry [MAX_ENTRIES];
   logic                 cell_before [MAX_ENTRIES];
   entry_type            head;

   logic req_fire, rsp_free, load_rsp;
   logic nonempty, full, at_budget, new_min, reject, evict_go;

   assign head     = cell_entry[0];
   assign req_fire = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // decisions taken against the state seen at accept
   assign nonempty  = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(MAX_ENTRIES));
   assign at_budget = (CMP_W'(sum_ff) >= CMP_W'(budget_ff));
   assign new_min   = (req_entry_score <= head.score);
   assign reject    = nonempty && at_budget && new_min;

   // keep dropping the head while the rest still exceeds the budget
   assign evict_go = (count_ff > CNT_W'(1)) &&
                     (CMP_W'(sum_ff - SUM_W'(head.length)) > CMP_W'(budget_ff));

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (reject) begin
                  state_in = ST_FINISH;
               end else if (full) begin
                  state_in = ST_DROP;
               end else begin
                  state_in = ST_INSERT;
               end
            end
         end
         ST_DROP:   state_in = ST_INSERT;
         ST_INSERT: state_in = evict_en_ff ? ST_EVICT : ST_FINISH;
         ST_EVICT: begin
            if (!evict_go) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // state outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      cell_cmd  = CMD_HOLD;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_DROP:   cell_cmd  = CMD_SHIFT_LEFT;
         ST_INSERT: cell_cmd  = CMD_INSERT;
         ST_EVICT:  cell_cmd  = evict_go ? CMD_SHIFT_LEFT : CMD_HOLD;
         ST_FINISH: load_rsp  = rsp_free;
         default:   cell_cmd  = CMD_HOLD;
      endcase
   end

   assign cell_ctrl.cmd       = cell_cmd;
   assign cell_ctrl.front     = front_ff;
   assign cell_ctrl.new_entry = work_ff;

   // ---------------------------------------------------------------------
   // cell chain, index 0 is the head (lowest score)
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      before_left;
      logic      occ;

      assign occ = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_e      = '0;
         assign before_left = 1'b1;
      end else begin : g_mid
         assign left_e      = cell_entry[i-1];
         assign before_left = cell_before[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_body
         assign right_e = cell_entry[i+1];
      end

      sslbb_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .occupied    (occ),
         .left_entry  (left_e),
         .right_entry (right_e),
         .before_in   (before_left),
         .entry       (cell_entry[i]),
         .before_out  (cell_before[i])
      );
   end

   // ---------------------------------------------------------------------
   // count, sum, request latches
   // ---------------------------------------------------------------------
   always_comb begin
      count_in    = count_ff;
      sum_in      = sum_ff;
      evicted_in  = evicted_ff;
      work_in     = work_ff;
      front_in    = front_ff;
      evict_en_in = evict_en_ff;
      accepted_in = accepted_ff;
      overflow_in = overflow_ff;
      budget_in   = budget_ff;

      unique case (cell_cmd)
         CMD_SHIFT_LEFT: begin
            count_in = count_ff - CNT_W'(1);
            sum_in   = sum_ff - SUM_W'(head.length);
            // the overflow drop is not an eviction
            if (state_ff == ST_EVICT) begin
               evicted_in = evicted_ff + CNT_W'(1);
            end
         end
         CMD_INSERT: begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = sum_ff + SUM_W'(work_ff.length);
         end
         default: begin
            count_in = count_ff;
         end
      endcase

      if (req_fire) begin
         work_in.length = req_entry_length;
         work_in.score  = req_entry_score;
         front_in       = new_min && !at_budget;
         evict_en_in    = nonempty && at_budget;
         accepted_in    = !reject;
         overflow_in    = !reject && full;
         evicted_in     = '0;
      end

      if (csr_valid && csr_ready) begin
         budget_in = csr_length_budget;
      end
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_accepted_in = rsp_accepted_ff;
      rsp_evicted_in  = rsp_evicted_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_lowest_in   = rsp_lowest_ff;
      rsp_valid_in    = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in    = 1'b1;
         rsp_accepted_in = accepted_ff;
         rsp_evicted_in  = COUNT_OUT_W'(evicted_ff);
         rsp_overflow_in = overflow_ff;
         rsp_count_in    = COUNT_OUT_W'(count_ff);
         // clamp the wide sum to the reported width
         rsp_total_in    = (CMP_W'(sum_ff) > CMP_W'(TOTAL_MAX)) ?
                           TOTAL_MAX : BUDGET_W'(sum_ff);
         rsp_lowest_in   = nonempty ? head.score : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         budget_ff    <= BUDGET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         budget_ff    <= budget_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only, no reset needed
   always_ff @(posedge clock) begin
      work_ff         <= work_in;
      front_ff        <= front_in;
      evict_en_ff     <= evict_en_in;
      accepted_ff     <= accepted_in;
      overflow_ff     <= overflow_in;
      evicted_ff      <= evicted_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_evicted_ff  <= rsp_evicted_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_lowest_ff   <= rsp_lowest_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_accepted          = rsp_accepted_ff;
   assign rsp_evicted_count     = rsp_evicted_ff;
   assign rsp_capacity_overflow = rsp_overflow_ff;
   assign rsp_entry_count       = rsp_count_ff;
   assign rsp_total_length      = rsp_total_ff;
   assign rsp_lowest_score      = rsp_lowest_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `SSLBB_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(MAX_ENTRIES), "entry count above capacity")
   `SSLBB_ASSERT_NOW(a_drop_only_full, clock, reset, state_ff == ST_DROP,
      count_ff == CNT_W'(MAX_ENTRIES), "head drop without a full bin")
   `SSLBB_ASSERT_NOW(a_evict_nonempty, clock, reset, state_ff == ST_EVICT,
      count_ff != '0, "eviction pass on an empty bin")
   `SSLBB_ASSERT_NEXT(a_insert_grows, clock, reset, state_ff == ST_INSERT,
      count_ff != '0, "insert left the bin empty")
   `SSLBB_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire,
      state_ff != ST_IDLE, "accepted request did not start work")

endmodule

>>> verif/score_sorted_length_budget_bin_checker.sv
// response checker for the score-sorted length budget bin: models the bin and compares results
`timescale 1ns / 1ps

module score_sorted_length_budget_bin_checker
   import sslbb_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [LEN_W-1:0]       req_entry_length,
   input  logic [SCORE_W-1:0]     req_entry_score,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_accepted,
   input  logic [COUNT_OUT_W-1:0] rsp_evicted_count,
   input  logic                   rsp_capacity_overflow,
   input  logic [COUNT_OUT_W-1:0] rsp_entry_count,
   input  logic [BUDGET_W-1:0]    rsp_total_length,
   input  logic [SCORE_W-1:0]     rsp_lowest_score,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [BUDGET_W-1:0]    csr_length_budget,
   output int                     mismatch_count,
   output int                     outstanding,
   output int                     results_checked,
   output int                     rejects_seen,
   output int                     evictions_seen,
   output int                     overflows_seen
);

   localparam int PRINT_LIMIT = 100;

   typedef struct packed {
      logic                   accepted;
      logic [COUNT_OUT_W-1:0] evicted_count;
      logic                   capacity_overflow;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic [BUDGET_W-1:0]    total_length;
      logic [SCORE_W-1:0]     lowest_score;
   } bin_outcome_type;

   // model of the bin, index 0 is the lowest score
   logic [SCORE_W-1:0]  held_score  [MAX_ENTRIES];
   logic [LEN_W-1:0]    held_length [MAX_ENTRIES];
   int                  held_entries = 0;
   int unsigned         held_total   = 0;
   logic [BUDGET_W-1:0] budget       = BUDGET_RESET;

   bin_outcome_type pending_outcomes [$];

   int mismatches = 0;
   int checked    = 0;
   int rejects    = 0;
   int evictions  = 0;
   int overflows  = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   function automatic void drop_front();
      int i;
      held_total -= held_length[0];
      for (i = 1; i < held_entries; i++) begin
         held_score[i-1]  = held_score[i];
         held_length[i-1] = held_length[i];
      end
      held_entries--;
   endfunction

   function automatic void place_entry(input int pos, input logic [LEN_W-1:0] len,
                                       input logic [SCORE_W-1:0] sc);
      int i;
      for (i = held_entries; i > pos; i--) begin
         held_score[i]  = held_score[i-1];
         held_length[i] = held_length[i-1];
      end
      held_score[pos]  = sc;
      held_length[pos] = len;
      held_entries++;
      held_total += len;
   endfunction

   function automatic bin_outcome_type bin_after_entry(input logic [LEN_W-1:0] len,
                                                       input logic [SCORE_W-1:0] sc);
      bin_outcome_type outcome;
      logic            at_budget;
      logic            new_min;
      int              pos;
      int              evicted;
      outcome          = '0;
      outcome.accepted = 1'b1;
      evicted          = 0;
      if (held_entries == 0) begin
         held_total = 0;
         place_entry(0, len, sc);
      end else begin
         at_budget = held_total >= budget;
         new_min   = sc <= held_score[0];
         if (at_budget && new_min) begin
            outcome.accepted = 1'b0;
         end else begin
            // full store: head goes first, new-minimum test already made
            if (held_entries >= MAX_ENTRIES) begin
               drop_front();
               outcome.capacity_overflow = 1'b1;
            end
            pos = 0;
            if (!(new_min && !at_budget)) begin
               while (pos < held_entries && held_score[pos] <= sc) pos++;
            end
            place_entry(pos, len, sc);
            if (at_budget) begin
               while (held_entries > 1 && held_total - held_length[0] > budget) begin
                  drop_front();
                  evicted++;
               end
            end
         end
      end
      outcome.evicted_count = evicted[COUNT_OUT_W-1:0];
      outcome.entry_count   = held_entries[COUNT_OUT_W-1:0];
      outcome.total_length  = (held_total > TOTAL_MAX) ? TOTAL_MAX : held_total[BUDGET_W-1:0];
      outcome.lowest_score  = (held_entries > 0) ? held_score[0] : '0;
      return outcome;
   endfunction

   always @(posedge clock) begin
      bin_outcome_type seen;
      bin_outcome_type want;
      if (reset) begin
         budget       = BUDGET_RESET;
         held_entries = 0;
         held_total   = 0;
         pending_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            budget = csr_length_budget;
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_accepted, rsp_evicted_count, rsp_capacity_overflow,
                     rsp_entry_count, rsp_total_length, rsp_lowest_score};
            if (pending_outcomes.size() == 0) begin
               report_mismatch("response with no request waiting", seen.entry_count, 0);
            end else begin
               want = pending_outcomes.pop_front();
               checked++;
               if (!want.accepted) rejects++;
               evictions += want.evicted_count;
               overflows += want.capacity_overflow;
               if (seen.accepted !== want.accepted)
                  report_mismatch("accepted", seen.accepted, want.accepted);
               if (seen.evicted_count !== want.evicted_count)
                  report_mismatch("evicted_count", seen.evicted_count, want.evicted_count);
               if (seen.capacity_overflow !== want.capacity_overflow)
                  report_mismatch("capacity_overflow", seen.capacity_overflow,
                                  want.capacity_overflow);
               if (seen.entry_count !== want.entry_count)
                  report_mismatch("entry_count", seen.entry_count, want.entry_count);
               if (seen.total_length !== want.total_length)
                  report_mismatch("total_length", seen.total_length, want.total_length);
               if (seen.lowest_score !== want.lowest_score)
                  report_mismatch("lowest_score", seen.lowest_score, want.lowest_score);
            end
         end
         if (req_valid && req_ready) begin
            pending_outcomes.push_back(bin_after_entry(req_entry_length, req_entry_score));
         end
      end
      mismatch_count  <= mismatches;
      outstanding     <= pending_outcomes.size();
      results_checked <= checked;
      rejects_seen    <= rejects;
      evictions_seen  <= evictions;
      overflows_seen  <= overflows;
   end

endmodule

>>> verif/score_sorted_length_budget_bin_tb.sv
// testbench top for the score-sorted length budget bin: stimulus, idling and verdict
`timescale 1ns / 1ps

module score_sorted_length_budget_bin_tb;
   import sslbb_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SEGMENT_ITEMS = 101;
   // longest request: a head drop, the insert and a run of up to 15 evictions
   localparam int SETTLE_CYCLES = 30;

   logic                   clock                 = 1'b0;
   logic                   reset                 = 1'b1;
   logic                   req_valid             = 1'b0;
   logic                   req_ready;
   logic [LEN_W-1:0]       req_entry_length      = '0;
   logic [SCORE_W-1:0]     req_entry_score       = '0;
   logic                   rsp_valid;
   logic                   rsp_ready             = 1'b0;
   logic                   rsp_accepted;
   logic [COUNT_OUT_W-1:0] rsp_evicted_count;
   logic                   rsp_capacity_overflow;
   logic [COUNT_OUT_W-1:0] rsp_entry_count;
   logic [BUDGET_W-1:0]    rsp_total_length;
   logic [SCORE_W-1:0]     rsp_lowest_score;
   logic                   csr_valid             = 1'b0;
   logic                   csr_ready;
   logic [BUDGET_W-1:0]    csr_length_budget     = '0;

   // handed up by the checker
   int mismatch_count;
   int outstanding;
   int results_checked;
   int rejects_seen;
   int evictions_seen;
   int overflows_seen;

   // idle mix, in percent of cycles
   int send_idle_pct = 24;
   int recv_idle_pct = 58;

   int requests_sent   = 0;
   int budgets_written = 0;
   int cycle_count     = 0;

   always #5 clock = ~clock;

   score_sorted_length_budget_bin DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_entry_length      (req_entry_length),
      .req_entry_score       (req_entry_score),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_accepted          (rsp_accepted),
      .rsp_evicted_count     (rsp_evicted_count),
      .rsp_capacity_overflow (rsp_capacity_overflow),
      .rsp_entry_count       (rsp_entry_count),
      .rsp_total_length      (rsp_total_length),
      .rsp_lowest_score      (rsp_lowest_score),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_length_budget     (csr_length_budget)
   );

   // the checker sits beside the block and only watches its ports
   score_sorted_length_budget_bin_checker bin_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_entry_length      (req_entry_length),
      .req_entry_score       (req_entry_score),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_accepted          (rsp_accepted),
      .rsp_evicted_count     (rsp_evicted_count),
      .rsp_capacity_overflow (rsp_capacity_overflow),
      .rsp_entry_count       (rsp_entry_count),
      .rsp_total_length      (rsp_total_length),
      .rsp_lowest_score      (rsp_lowest_score),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_length_budget     (csr_length_budget),
      .mismatch_count        (mismatch_count),
      .outstanding           (outstanding),
      .results_checked       (results_checked),
      .rejects_seen          (rejects_seen),
      .evictions_seen        (evictions_seen),
      .overflows_seen        (overflows_seen)
   );

   // receiver back-pressure, one decision per cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog on total run length
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("score_sorted_length_budget_bin verification failed");
      $finish;
   end

   // offer one request; valid stays high from one request to the next unless
   // a gap is drawn, so it is never lowered and raised in the same step
   task automatic offer_entry(input logic [LEN_W-1:0] len, input logic [SCORE_W-1:0] sc);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_entry_length <= len;
      req_entry_score  <= sc;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   // stop offering, wait for every response, then let the block fall idle
   task automatic settle_bin();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_budget(input logic [BUDGET_W-1:0] value);
      csr_valid         <= 1'b1;
      csr_length_budget <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      budgets_written++;
   endtask

   initial begin
      int                  mix;
      int                  seg;
      int                  n;
      int                  trend;
      logic [LEN_W-1:0]    len;
      logic [SCORE_W-1:0]  sc;
      logic [SCORE_W-1:0]  last_score;
      logic [BUDGET_W-1:0] budget;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed, reset budget of 300
      offer_entry(16'd100, 16'd500);    // empty bin takes anything
      offer_entry(16'd50, 16'd500);     // tie with head below budget: goes in front
      offer_entry(16'd60, 16'd700);     // after all lower scores
      offer_entry(16'd40, 16'd600);     // lands in the middle
      offer_entry(16'd0, 16'd0);        // zero length, zero score, new minimum
      offer_entry(16'hFFFF, 16'hFFFF);  // both fields at max, pushes sum past budget
      offer_entry(16'd10, 16'd0);       // at budget and not above head: rejected
      offer_entry(16'd20, 16'd800);     // at budget: insert then a run of evictions

      // budget out of reach: fill the store and force head drops
      settle_bin();
      write_budget(TOTAL_MAX);
      for (n = 0; n < 15; n++) begin
         offer_entry(16'(n * 7), 16'(1000 + n * 100));
      end
      offer_entry(16'd7, 16'hFFFF);     // full store, high score: head dropped
      offer_entry(16'd9, 16'd0);        // full store, new minimum judged before the drop

      // random part: three idle mixes, each walking through a set of budgets
      last_score = '0;
      for (mix = 0; mix < 3; mix++) begin
         case (mix)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (seg = 0; seg < 6; seg++) begin
            // max budget first so low scores can reopen the bin
            case (seg)
               0: budget = TOTAL_MAX;
               1: budget = '0;
               2: budget = 20'($urandom_range(1000, 20));
               3: budget = 20'd1;
               4: budget = 20'($urandom_range(300000, 1000));
               default: budget = BUDGET_RESET;
            endcase
            settle_bin();
            write_budget(budget);
            // scores mostly ride a slowly rising level so that entries keep
            // beating the head once the budget is reached
            trend = $urandom_range(30000);
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
               trend = trend + $urandom_range(40);
               if (trend > 65535) trend = 65535;
               case ($urandom_range(9))
                  0: sc = $urandom_range(1) ? '1 : '0;
                  1: sc = 16'($urandom_range(65535));
                  2: sc = last_score;
                  default: sc = trend[SCORE_W-1:0];
               endcase
               case ($urandom_range(7))
                  0: len = '0;
                  1: len = '1;
                  2, 3: len = 16'($urandom_range(65535));
                  default: len = 16'($urandom_range(200, 1));
               endcase
               offer_entry(len, sc);
               last_score = sc;
            end
         end
      end

      settle_bin();
      $display("covered %0d requests over %0d budget writes, budgets from zero to full scale",
               requests_sent, budgets_written);
      $display("checked %0d responses: %0d rejects, %0d evictions, %0d overflow drops",
               results_checked, rejects_seen, evictions_seen, overflows_seen);
      if (mismatch_count == 0) begin
         $display("score_sorted_length_budget_bin verification clean");
      end else begin
         $display("score_sorted_length_budget_bin verification failed");
      end
      $finish;
   end

endmodule
